// ----- rtl/lchpg_pkg.sv -----
// ----------------------------------------------------------------------------
// lchpg_pkg
// shared types, codes and the divider step for the hsv pattern generator
// ----------------------------------------------------------------------------
package lchpg_pkg;

    localparam int PIXEL_COUNT = 32;

    localparam int PARAM_W = 27;
    localparam int INDEX_W = 16;
    localparam int ROW_W   = 5;
    localparam int BYTE_W  = 8;

    // stages inside one waveform unit: 4 remainder, 1 setup, 4 quotient, 1 result
    localparam int CHUNK_W  = 4;
    localparam int MOD_STG  = INDEX_W / CHUNK_W;
    localparam int DIV_STG  = INDEX_W / CHUNK_W;
    localparam int WAVE_LAT = MOD_STG + 1 + DIV_STG + 1;

    // waveform kinds
    localparam logic [2:0] WAVE_CONST = 3'd0;
    localparam logic [2:0] WAVE_RAMP  = 3'd1;
    localparam logic [2:0] WAVE_TRI   = 3'd2;
    localparam logic [2:0] WAVE_PULSE = 3'd3;

    // register indexes
    localparam logic [2:0] REG_X_HUE   = 3'd0;
    localparam logic [2:0] REG_X_SAT   = 3'd1;
    localparam logic [2:0] REG_X_VAL   = 3'd2;
    localparam logic [2:0] REG_Y_HUE   = 3'd3;
    localparam logic [2:0] REG_Y_SAT   = 3'd4;
    localparam logic [2:0] REG_Y_VAL   = 3'd5;
    localparam logic [2:0] REG_DEFAULT = 3'd6;
    localparam logic [2:0] REG_BLOCK   = 3'd7;

    typedef struct packed {
        logic [7:0] upper;
        logic [7:0] lower;
        logic [7:0] range;
        logic [2:0] kind;
    } wave_param_t;

    typedef struct packed {
        logic [7:0] rem;
        logic [3:0] q;
    } chunk_t;

    // four restoring division steps, dividend bits msb first
    function automatic chunk_t div_chunk(input logic [7:0] rem_in, input logic [3:0] bits,
                                         input logic [7:0] den);
        chunk_t     res;
        logic [8:0] r;
        r     = {1'b0, rem_in};
        res.q = '0;
        for (int i = 3; i >= 0; i--)
        begin
            r = {r[7:0], bits[i]};
            if (r >= {1'b0, den})
            begin
                r        = r - {1'b0, den};
                res.q[i] = 1'b1;
            end
        end
        res.rem = r[7:0];
        return res;
    endfunction

endpackage

// ----- rtl/lchpg_wave.sv -----
// ----------------------------------------------------------------------------
// lchpg_wave
// pipelined waveform unit: phase by remainder, then scaled by a quotient
// ----------------------------------------------------------------------------
module lchpg_wave (
    input  logic                     clk,
    input  logic                     en,
    input  logic [15:0]              t,
    input  lchpg_pkg::wave_param_t   prm,
    input  logic [7:0]               dflt,
    output logic [7:0]               wave
);
    import lchpg_pkg::*;

    // remainder stages
    logic [7:0]  mrem_reg [MOD_STG];
    logic [15:0] mdvd_reg [MOD_STG-1];
    chunk_t      mres     [MOD_STG];

    always_comb
    begin
        mres[0] = div_chunk(8'd0, t[15:12], prm.range);
        for (int s = 1; s < MOD_STG; s++)
            mres[s] = div_chunk(mrem_reg[s-1], mdvd_reg[s-1][15:12], prm.range);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < MOD_STG; s++)
                mrem_reg[s] <= mres[s].rem;
            mdvd_reg[0] <= {t[11:0], 4'b0};
            for (int s = 1; s < MOD_STG - 1; s++)
                mdvd_reg[s] <= {mdvd_reg[s-1][11:0], 4'b0};
        end
    end

    // setup: numerator and divisor per kind
    logic [7:0]  p, h, span, adiff, d;
    logic [15:0] num_next, num_reg;
    logic [7:0]  den_next, den_reg;
    logic        ge, ge_reg;

    always_comb
    begin
        p     = (prm.range != 8'd0) ? mrem_reg[MOD_STG-1] : 8'd0;
        h     = prm.range >> 1;
        span  = (p > h) ? (p - h) : (h - p);
        adiff = (prm.upper < prm.lower) ? (prm.lower - prm.upper) : (prm.upper - prm.lower);
        d     = prm.upper - prm.lower;
        ge    = (p >= prm.upper);
        num_next = '0;
        den_next = 8'd1;
        case (prm.kind)
            WAVE_RAMP:
            begin
                num_next = p * adiff;
                den_next = prm.range;
            end
            WAVE_TRI:
            begin
                num_next = span * d;
                den_next = h;
            end
            WAVE_PULSE:
            begin
                num_next = {5'b0, p - prm.upper, 3'b0};
                den_next = prm.range;
            end
            default:
            begin
                num_next = '0;
                den_next = 8'd1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
            ge_reg  <= ge;
        end
    end

    // quotient stages
    logic [7:0]  drem_reg [DIV_STG];
    logic [15:0] dnum_reg [DIV_STG-1];
    logic [15:0] q_reg    [DIV_STG];
    logic [7:0]  dden_reg [DIV_STG];
    logic        dge_reg  [DIV_STG];
    chunk_t      dres     [DIV_STG];

    always_comb
    begin
        dres[0] = div_chunk(8'd0, num_reg[15:12], den_reg);
        for (int s = 1; s < DIV_STG; s++)
            dres[s] = div_chunk(drem_reg[s-1], dnum_reg[s-1][15:12], dden_reg[s-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drem_reg[0] <= dres[0].rem;
            q_reg[0]    <= {12'b0, dres[0].q};
            dden_reg[0] <= den_reg;
            dge_reg[0]  <= ge_reg;
            dnum_reg[0] <= {num_reg[11:0], 4'b0};
            for (int s = 1; s < DIV_STG; s++)
            begin
                drem_reg[s] <= dres[s].rem;
                q_reg[s]    <= {q_reg[s-1][11:0], dres[s].q};
                dden_reg[s] <= dden_reg[s-1];
                dge_reg[s]  <= dge_reg[s-1];
            end
            for (int s = 1; s < DIV_STG - 1; s++)
                dnum_reg[s] <= {dnum_reg[s-1][11:0], 4'b0};
        end
    end

    // result
    logic [15:0] q;
    logic [16:0] tri_sum;
    logic [7:0]  wave_next, wave_reg;

    always_comb
    begin
        q       = q_reg[DIV_STG-1];
        tri_sum = {9'b0, prm.lower} + {1'b0, q};
        case (prm.kind)
            WAVE_CONST: wave_next = prm.upper;
            WAVE_RAMP:
            begin
                if (prm.range == 8'd0)
                    wave_next = prm.lower;
                else if (prm.upper < prm.lower)
                    wave_next = prm.lower - q[7:0];
                else
                    wave_next = prm.lower + q[7:0];
            end
            WAVE_TRI:
            begin
                if (prm.range < 8'd2)
                    wave_next = prm.lower;
                else if (tri_sum > 17'd255)
                    wave_next = 8'hff;
                else
                    wave_next = tri_sum[7:0];
            end
            WAVE_PULSE:
            begin
                if (prm.range == 8'd0 || !dge_reg[DIV_STG-1])
                    wave_next = 8'hff;
                else if (q >= 16'd8)
                    wave_next = 8'h00;
                else
                    wave_next = 8'hff >> q[2:0];
            end
            default: wave_next = dflt;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            wave_reg <= wave_next;
    end

    assign wave = wave_reg;

endmodule

// ----- rtl/led_column_hsv_pattern_generator.sv -----
// ----------------------------------------------------------------------------
// led_column_hsv_pattern_generator
// per-pixel hsv colour from column and row waveforms
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: column, row, replace hsv
//                                              tuser: restart, lit
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: hue, saturation, brightness
//  cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
//  one word per cycle while the output is not stalled; 12 register stages, and
//  m_axis_tvalid rises once the word has passed through all of them
//  stages: entry, 4 remainder stages for the phase, a setup stage with the
//  8x8 multiplies, 4 quotient stages, a waveform result stage and the combine stage
//  the whole pipeline holds while the output word waits (tready gates all stages)
//  reset clears valid bits and configuration registers; cfg is always ready
// ----------------------------------------------------------------------------
module led_column_hsv_pattern_generator #(
    parameter int PIXEL_COUNT = lchpg_pkg::PIXEL_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    // column_index[15:0], pixel_row[20:16], replace_hue[28:21],
    // replace_sat[36:29], replace_val[44:37], zero[47:45]
    input  logic [47:0] s_axis_tdata,
    // restart[0], lit[1]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // hue[7:0], saturation[15:8], brightness[23:16]
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [26:0] cfg_data
);
    import lchpg_pkg::*;

    localparam int LAT = WAVE_LAT + 2;

    typedef struct packed {
        logic       lit;
        logic       row_ok;
        logic [7:0] rh;
        logic [7:0] rs;
        logic [7:0] rv;
    } side_t;

    // configuration registers
    wave_param_t xh_reg, xs_reg, xv_reg, yh_reg, ys_reg, yv_reg;
    logic [7:0]  dflt_reg;
    logic [15:0] bsi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xh_reg   <= '0;
            xs_reg   <= '0;
            xv_reg   <= '0;
            yh_reg   <= '0;
            ys_reg   <= '0;
            yv_reg   <= '0;
            dflt_reg <= '0;
            bsi_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_HUE:   xh_reg   <= cfg_data;
                REG_X_SAT:   xs_reg   <= cfg_data;
                REG_X_VAL:   xv_reg   <= cfg_data;
                REG_Y_HUE:   yh_reg   <= cfg_data;
                REG_Y_SAT:   ys_reg   <= cfg_data;
                REG_Y_VAL:   yv_reg   <= cfg_data;
                REG_DEFAULT: dflt_reg <= cfg_data[7:0];
                REG_BLOCK:   bsi_reg  <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    // global stall: every stage moves when the output word is free or taken
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    // entry stage
    logic [15:0] col, t_next, t_reg;
    logic [4:0]  row, row_reg;
    side_t       side_next;
    side_t       side_reg [WAVE_LAT+1];

    always_comb
    begin
        col              = s_axis_tdata[15:0];
        row              = s_axis_tdata[20:16];
        t_next           = s_axis_tuser[0] ? (col - bsi_reg) : col;
        side_next.lit    = s_axis_tuser[1];
        side_next.row_ok = ({1'b0, row} < 6'(PIXEL_COUNT));
        side_next.rh     = s_axis_tdata[28:21];
        side_next.rs     = s_axis_tdata[36:29];
        side_next.rv     = s_axis_tdata[44:37];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg       <= t_next;
            row_reg     <= row;
            side_reg[0] <= side_next;
            for (int i = 1; i <= WAVE_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // six waveform units
    logic [15:0] row_t;
    logic [7:0]  wxh, wxs, wxv, wyh, wys, wyv;

    assign row_t = {11'b0, row_reg};

    lchpg_wave u_xh (.clk(clk), .en(en), .t(t_reg), .prm(xh_reg), .dflt(dflt_reg), .wave(wxh));
    lchpg_wave u_xs (.clk(clk), .en(en), .t(t_reg), .prm(xs_reg), .dflt(dflt_reg), .wave(wxs));
    lchpg_wave u_xv (.clk(clk), .en(en), .t(t_reg), .prm(xv_reg), .dflt(dflt_reg), .wave(wxv));
    lchpg_wave u_yh (.clk(clk), .en(en), .t(row_t), .prm(yh_reg), .dflt(dflt_reg), .wave(wyh));
    lchpg_wave u_ys (.clk(clk), .en(en), .t(row_t), .prm(ys_reg), .dflt(dflt_reg), .wave(wys));
    lchpg_wave u_yv (.clk(clk), .en(en), .t(row_t), .prm(yv_reg), .dflt(dflt_reg), .wave(wyv));

    // combine: hue wraps, saturation and value clamp; unlit pixels take the replace hsv, bad rows give zero
    logic [8:0]  s_sum, v_sum;
    logic [23:0] out_next, out_reg;
    side_t       sd;

    always_comb
    begin
        sd    = side_reg[WAVE_LAT];
        s_sum = {1'b0, wxs} + {1'b0, wys};
        v_sum = {1'b0, wxv} + {1'b0, wyv};
        if (!sd.row_ok)
            out_next = '0;
        else if (!sd.lit)
            out_next = {sd.rv, sd.rs, sd.rh};
        else
            out_next = {v_sum[8] ? 8'hff : v_sum[7:0],
                        s_sum[8] ? 8'hff : s_sum[7:0],
                        wxh + wyh};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign m_axis_tdata  = out_reg;
    assign m_axis_tvalid = vld_reg[LAT-1];

endmodule
